// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level allocator to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet during reset.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, quiet during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- design/mpfl_pkg.sv -----
// Shared types and constants for the multi-pool free-list allocator.
`timescale 1ns / 1ps

package mpfl_pkg;

  localparam int POOL_COUNT_DEF      = 4;
  localparam int BLOCKS_PER_POOL_DEF = 16;

  localparam int HEAD_SLOTS = 4;
  localparam int LINK_SLOTS = 64;
  localparam int POOL_W     = 2;
  localparam int HANDLE_W   = 6;
  localparam int LINK_W     = 7;

  // A link or head with its top bit set marks the end of a list.
  localparam logic [LINK_W-1:0] END_MARK = 7'd64;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } mpfl_state_e;

  typedef struct packed {
    logic load;  // capture the request and read the link store
    logic exec;  // update heads and links, register the result
  } mpfl_cmd_t;

endpackage

// ----- design/multi_pool_free_list_allocator.sv -----
// Multi-pool free-list allocator: one LIFO free list per pool, shared link store.
// A word's request and the link entry under its pool's head are registered when it is accepted.
// The result is registered in the execute state; no new word is taken until that state ends.
// Reset chains each pool in order, so its highest block is handed out first; no clearing pass.
// The result strobe done_o lasts one cycle and the receiver cannot stall it.
`timescale 1ns / 1ps

module multi_pool_free_list_allocator
  import mpfl_pkg::*;
#(
  parameter int POOL_COUNT      = POOL_COUNT_DEF,
  parameter int BLOCKS_PER_POOL = BLOCKS_PER_POOL_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                kind_i,
  input  logic [POOL_W-1:0]   pool_i,
  input  logic [HANDLE_W-1:0] block_i,
  input  logic                block_is_null_i,
  output logic                done_o,
  output logic                granted_o,
  output logic [HANDLE_W-1:0] handle_o
);

  `include "assert_macros.svh"

  mpfl_cmd_t cmd;

  // The controller takes a word when idle and then moves to its execute state.
  // In the accept cycle the datapath reads the link entry under the pool's
  // head; in the execute cycle it pops or pushes and registers the result,
  // so heads and links are current before the next word is read.
  mpfl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  mpfl_dp #(
    .POOL_COUNT      (POOL_COUNT),
    .BLOCKS_PER_POOL (BLOCKS_PER_POOL)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .kind_i          (kind_i),
    .pool_i          (pool_i),
    .block_i         (block_i),
    .block_is_null_i (block_is_null_i),
    .done_o          (done_o),
    .granted_o       (granted_o),
    .handle_o        (handle_o)
  );

  // An accepted word always moves the controller into its execute cycle.
  `ASSERT_NEXT(a_accept_then_busy, start && !busy, busy)
  // Every execute cycle produces exactly one result in the following cycle.
  `ASSERT_NEXT(a_busy_then_done, busy, done_o && !busy)
  // A result that grants nothing carries a zero handle.
  `ASSERT_NOW(a_nogrant_zero, done_o && !granted_o, handle_o == '0)

endmodule

// ----- design/mpfl_ctrl.sv -----
// Controller state machine that sequences one request through the datapath.
`timescale 1ns / 1ps

module mpfl_ctrl
  import mpfl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output mpfl_cmd_t cmd_o
);

  mpfl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    busy_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy_o     = 1'b1;
        cmd_o.exec = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/mpfl_dp.sv -----
// Datapath: pool head registers, shared link store and result registers.
`timescale 1ns / 1ps

module mpfl_dp
  import mpfl_pkg::*;
#(
  parameter int POOL_COUNT      = POOL_COUNT_DEF,
  parameter int BLOCKS_PER_POOL = BLOCKS_PER_POOL_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mpfl_cmd_t           cmd_i,
  input  logic                kind_i,
  input  logic [POOL_W-1:0]   pool_i,
  input  logic [HANDLE_W-1:0] block_i,
  input  logic                block_is_null_i,
  output logic                done_o,
  output logic                granted_o,
  output logic [HANDLE_W-1:0] handle_o
);

  // Reset contents, fixed at elaboration.
  logic [LINK_W-1:0] link_rst [LINK_SLOTS];
  logic [LINK_W-1:0] head_rst [HEAD_SLOTS];

  for (genvar g = 0; g < LINK_SLOTS; g++) begin : g_link_rst
    localparam int P = g / BLOCKS_PER_POOL;
    localparam int J = g % BLOCKS_PER_POOL;
    assign link_rst[g] = (P < POOL_COUNT && J != 0) ? LINK_W'(g - 1) : END_MARK;
  end

  for (genvar p = 0; p < HEAD_SLOTS; p++) begin : g_head_rst
    localparam int FIRST = p * BLOCKS_PER_POOL;
    localparam int LAST  = (FIRST + BLOCKS_PER_POOL - 1 < LINK_SLOTS) ?
                           FIRST + BLOCKS_PER_POOL - 1 : LINK_SLOTS - 1;
    assign head_rst[p] = (p < POOL_COUNT && FIRST < LINK_SLOTS) ? LINK_W'(LAST) : END_MARK;
  end

  logic [LINK_W-1:0]   head_q [HEAD_SLOTS];
  logic [LINK_W-1:0]   link_mem_q [LINK_SLOTS];
  logic [LINK_SLOTS-1:0] link_vld_q;

  logic                kind_q, null_q;
  logic [POOL_W-1:0]   pool_q;
  logic [HANDLE_W-1:0] block_q;
  logic [LINK_W-1:0]   rd_data_q, rd_rst_q;
  logic                rd_vld_q;
  logic                done_q, granted_q;
  logic [HANDLE_W-1:0] handle_q;

  logic [HANDLE_W-1:0] rd_addr;
  logic [LINK_W-1:0]   head_cur, link_val;
  logic                active, do_pop, do_push;

  // The link read is aimed at the current head of the addressed pool.
  assign rd_addr  = head_q[pool_i][HANDLE_W-1:0];
  assign head_cur = head_q[pool_q];
  assign link_val = rd_vld_q ? rd_data_q : rd_rst_q;
  assign active   = int'(pool_q) < POOL_COUNT;
  assign do_pop   = cmd_i.exec && kind_q == KIND_ALLOC && active && !head_cur[LINK_W-1];
  assign do_push  = cmd_i.exec && kind_q == KIND_FREE && active && !null_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q    <= kind_i;
      pool_q    <= pool_i;
      block_q   <= block_i;
      null_q    <= block_is_null_i;
      rd_data_q <= link_mem_q[rd_addr];
      rd_rst_q  <= link_rst[rd_addr];
    end
    if (do_push) begin
      link_mem_q[block_q] <= head_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rd_vld_q <= link_vld_q[rd_addr];
      end
      if (do_push) begin
        link_vld_q[block_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HEAD_SLOTS; i++) begin
        head_q[i] <= head_rst[i];
      end
    end else begin
      if (do_pop) begin
        head_q[pool_q] <= link_val;
      end else if (do_push) begin
        head_q[pool_q] <= {1'b0, block_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      granted_q <= do_pop;
      handle_q  <= do_pop ? head_cur[HANDLE_W-1:0] : '0;
    end
  end

  assign done_o    = done_q;
  assign granted_o = granted_q;
  assign handle_o  = handle_q;

endmodule
